// ----- sv/hall_sine_commutation_core_defines.svh -----
// Assertion macros shared by the commutation core files.
`ifndef HALL_SINE_COMMUTATION_CORE_DEFINES_SVH
`define HALL_SINE_COMMUTATION_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define HSC_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error(msg);
`define HSC_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HSC_ASSERT(label, clock, reset, prop, msg)
`define HSC_ASSERT_NEXT(label, clock, reset, ante, cons, msg)
`endif

`endif

// ----- sv/hsc_pkg.sv -----
package hsc_pkg;

  localparam int TABLE_LEN_DEF = 400;
  localparam int WINDOW_DEF    = 101;
  localparam int AMPLITUDE_DEF = 1760;

  localparam int DATA_W  = 12;
  localparam int MAG_W   = DATA_W - 1;
  localparam int PROD_W  = MAG_W + DATA_W;
  localparam int SCALE_W = PROD_W + 13;
  localparam int SUM_W   = 19;
  localparam int COUNT_W = 7;
  localparam int STEP_W  = 3;
  localparam int HALL_W  = 3;

  localparam int GAIN_MUL   = 4097;
  localparam int GAIN_SHIFT = 24;

  localparam logic [DATA_W-1:0] RESET_MIN_LEVEL = 12'd500;
  localparam logic [DATA_W-1:0] RESET_CENTER    = 12'd1760;

  // Register index (paddr[2])
  localparam logic REG_MIN_LEVEL = 1'b0;
  localparam logic REG_CENTER    = 1'b1;

  // Hall codes, bit0 H1, bit1 H2, bit2 H3
  localparam logic [HALL_W-1:0] HALL_STEP1 = 3'b101;
  localparam logic [HALL_W-1:0] HALL_STEP2 = 3'b001;
  localparam logic [HALL_W-1:0] HALL_STEP3 = 3'b011;
  localparam logic [HALL_W-1:0] HALL_STEP4 = 3'b010;
  localparam logic [HALL_W-1:0] HALL_STEP5 = 3'b110;
  localparam logic [HALL_W-1:0] HALL_STEP6 = 3'b100;

  localparam logic [STEP_W-1:0] STEP_INVALID = 3'd0;

  typedef struct packed {
    logic en_prod;
    logic en_out;
  } lane_ctl_t;

  function automatic logic [STEP_W-1:0] hall_step(input logic [HALL_W-1:0] code);
    logic [STEP_W-1:0] s;
    unique case (code)
      HALL_STEP1: s = 3'd1;
      HALL_STEP2: s = 3'd2;
      HALL_STEP3: s = 3'd3;
      HALL_STEP4: s = 3'd4;
      HALL_STEP5: s = 3'd5;
      HALL_STEP6: s = 3'd6;
      default:    s = STEP_INVALID;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/hall_sine_commutation_core.sv -----
// Hall-sensor sinusoidal commutation core.
// Input channel (in_valid/in_stall): action 0 carries an ADC sample into the
// averaging window; action 1 is a PWM tick carrying the Hall bits. Output
// channel (out_valid/out_stall): one result per tick with the three phase
// compare values, the decoded step and the Hall fault flag; ADC samples give
// no result.
// Pipeline: a tick's result passes the sine memory read at the transfer
// edge, then the gain multiply, then scale and saturate into the output
// registers. Throughput: one item per cycle when the output is not stalled
// and the table sweep has ended; the sine memory reads are registered.
// A new gain level from the final sample of a window is used by any tick
// that follows it, including one in the very next cycle.
// Reset: the sine table is swept into the memories, one entry per cycle,
// writing all TABLE_LEN entries (400 by default); in_stall stays high until
// the sweep ends. Configuration writes are taken throughout.
// Stall: a result held on a stalled output does not stop the pipeline; up to
// two further ticks advance behind it before in_stall rises.
`include "hall_sine_commutation_core_defines.svh"

module hall_sine_commutation_core #(
  parameter int TABLE_LEN = hsc_pkg::TABLE_LEN_DEF,
  parameter int WINDOW    = hsc_pkg::WINDOW_DEF,
  parameter int AMPLITUDE = hsc_pkg::AMPLITUDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [hsc_pkg::DATA_W-1:0] sample,
  input  logic [hsc_pkg::HALL_W-1:0] hall_bits,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hsc_pkg::DATA_W-1:0] compare_u,
  output logic [hsc_pkg::DATA_W-1:0] compare_v,
  output logic [hsc_pkg::DATA_W-1:0] compare_w,
  output logic [hsc_pkg::STEP_W-1:0] step_out,
  output logic                       hall_fault
);

  localparam int AW    = $clog2(TABLE_LEN);
  localparam int DW    = hsc_pkg::DATA_W;
  localparam int SIXTH = TABLE_LEN / 6;
  localparam int THIRD = TABLE_LEN / 3;
  localparam logic [AW:0] TBL_END = (AW+1)'(TABLE_LEN);

  logic [DW-1:0] min_level, center_value, gain_level;

  logic          fill_busy;
  logic [AW-1:0] fill_addr;
  logic [DW-1:0] fill_data;

  logic en_out, en_prod, en_read, accept, tick, adc;
  logic rd_valid, prod_valid;
  hsc_pkg::lane_ctl_t lane_ctl;

  logic [AW-1:0] phase_counter, phase_next, offset, idx_u, idx_v, idx_w;
  logic [AW:0]   sum_u, sum_v, sum_w;
  logic [hsc_pkg::STEP_W-1:0] step_in, step_rd, step_prod;

  logic [AW-1:0] raddr_uv [2];
  logic [AW-1:0] raddr_w  [1];
  logic [DW-1:0] rdata_uv [2];
  logic [DW-1:0] rdata_w  [1];

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level    <= hsc_pkg::RESET_MIN_LEVEL;
      center_value <= hsc_pkg::RESET_CENTER;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        hsc_pkg::REG_MIN_LEVEL: min_level    <= pwdata[DW-1:0];
        hsc_pkg::REG_CENTER:    center_value <= pwdata[DW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hsc_pkg::REG_MIN_LEVEL: prdata = 32'(min_level);
      hsc_pkg::REG_CENTER:    prdata = 32'(center_value);
    endcase
  end

  // Pipeline control: each stage moves when the one after it has room
  assign en_out   = !out_valid || !out_stall;
  assign en_prod  = !prod_valid || en_out;
  assign en_read  = !rd_valid || en_prod;
  assign in_stall = fill_busy || !en_read;
  assign accept   = in_valid && !in_stall;
  assign tick     = accept && action;
  assign adc      = accept && !action;

  assign lane_ctl.en_prod = en_prod;
  assign lane_ctl.en_out  = en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (en_read) rd_valid   <= tick;
      if (en_prod) prod_valid <= rd_valid;
      if (en_out)  out_valid  <= prod_valid;
    end
  end

  // Phase and table addresses
  assign phase_next = (phase_counter == AW'(TABLE_LEN - 1)) ? '0 : phase_counter + AW'(1);
  assign step_in    = hsc_pkg::hall_step(hall_bits);
  assign offset     = (step_in == hsc_pkg::STEP_INVALID)
                      ? AW'(TABLE_LEN - SIXTH)
                      : AW'((int'(step_in) - 1) * SIXTH);

  assign sum_u = {1'b0, phase_next} + {1'b0, offset};
  assign idx_u = (sum_u >= (AW+1)'(TABLE_LEN)) ? AW'(sum_u - (AW+1)'(TABLE_LEN)) : AW'(sum_u);
  assign sum_v = {1'b0, idx_u} + (AW+1)'(THIRD);
  assign idx_v = (sum_v >= (AW+1)'(TABLE_LEN)) ? AW'(sum_v - (AW+1)'(TABLE_LEN)) : AW'(sum_v);
  assign sum_w = {1'b0, idx_u} + (AW+1)'(2 * THIRD);
  assign idx_w = (sum_w >= (AW+1)'(TABLE_LEN)) ? AW'(sum_w - (AW+1)'(TABLE_LEN)) : AW'(sum_w);

  assign raddr_uv[0] = idx_u;
  assign raddr_uv[1] = idx_v;
  assign raddr_w[0]  = idx_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_counter <= '0;
    end else if (tick) begin
      phase_counter <= phase_next;
    end
  end

  // Step travels alongside the lanes
  always_ff @(posedge clk) begin
    if (en_read) step_rd   <= step_in;
    if (en_prod) step_prod <= step_rd;
    if (en_out) begin
      step_out   <= step_prod;
      hall_fault <= (step_prod == hsc_pkg::STEP_INVALID);
    end
  end

  hsc_table_fill #(
    .TABLE_LEN (TABLE_LEN),
    .AMPLITUDE (AMPLITUDE)
  ) u_fill (
    .clk   (clk),
    .rst   (rst),
    .busy  (fill_busy),
    .waddr (fill_addr),
    .wdata (fill_data)
  );

  hsc_ram #(
    .WIDTH    (DW),
    .DEPTH    (TABLE_LEN),
    .RD_PORTS (2)
  ) u_sine_uv (
    .clk   (clk),
    .we    (fill_busy),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (en_read),
    .raddr (raddr_uv),
    .rdata (rdata_uv)
  );

  hsc_ram #(
    .WIDTH    (DW),
    .DEPTH    (TABLE_LEN),
    .RD_PORTS (1)
  ) u_sine_w (
    .clk   (clk),
    .we    (fill_busy),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (en_read),
    .raddr (raddr_w),
    .rdata (rdata_w)
  );

  hsc_gain #(
    .WINDOW (WINDOW)
  ) u_gain (
    .clk        (clk),
    .rst        (rst),
    .adc        (adc),
    .sample     (sample),
    .min_level  (min_level),
    .gain_level (gain_level)
  );

  hsc_drive_lane u_lane_u (
    .clk          (clk),
    .ctl          (lane_ctl),
    .entry        (rdata_uv[0]),
    .gain_level   (gain_level),
    .center_value (center_value),
    .compare      (compare_u)
  );

  hsc_drive_lane u_lane_v (
    .clk          (clk),
    .ctl          (lane_ctl),
    .entry        (rdata_uv[1]),
    .gain_level   (gain_level),
    .center_value (center_value),
    .compare      (compare_v)
  );

  hsc_drive_lane u_lane_w (
    .clk          (clk),
    .ctl          (lane_ctl),
    .entry        (rdata_w[0]),
    .gain_level   (gain_level),
    .center_value (center_value),
    .compare      (compare_w)
  );

  `HSC_ASSERT(a_phase_range, clk, rst, ({1'b0, phase_counter} < TBL_END),
              "phase counter out of table range")
  `HSC_ASSERT(a_addr_range, clk, rst,
              !tick || (({1'b0, idx_u} < TBL_END) && ({1'b0, idx_v} < TBL_END) && ({1'b0, idx_w} < TBL_END)),
              "sine read address out of table range")
  `HSC_ASSERT(a_fault_step, clk, rst,
              !out_valid || (hall_fault == (step_out == hsc_pkg::STEP_INVALID)),
              "fault flag disagrees with step")

endmodule

// ----- sv/hsc_ram.sv -----
module hsc_ram #(
  parameter int WIDTH    = 12,
  parameter int DEPTH    = 400,
  parameter int RD_PORTS = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr [RD_PORTS],
  output logic [WIDTH-1:0]         rdata [RD_PORTS]
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      for (int p = 0; p < RD_PORTS; p++) begin
        rdata[p] <= mem[raddr[p]];
      end
    end
  end

endmodule

// ----- sv/hsc_table_fill.sv -----
module hsc_table_fill #(
  parameter int TABLE_LEN = hsc_pkg::TABLE_LEN_DEF,
  parameter int AMPLITUDE = hsc_pkg::AMPLITUDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  output logic                         busy,
  output logic [$clog2(TABLE_LEN)-1:0] waddr,
  output logic [hsc_pkg::DATA_W-1:0]   wdata
);

  localparam int AW = $clog2(TABLE_LEN);
  localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;

  function automatic logic [63:0] q61_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[124:61];
  endfunction

  function automatic logic [63:0] series_div(input logic [63:0] v, input int k);
    logic [63:0] r;
    unique case (k)
      1:       r = v / 64'd6;
      2:       r = v / 64'd20;
      3:       r = v / 64'd42;
      4:       r = v / 64'd72;
      5:       r = v / 64'd110;
      6:       r = v / 64'd156;
      7:       r = v / 64'd210;
      8:       r = v / 64'd272;
      9:       r = v / 64'd342;
      10:      r = v / 64'd420;
      11:      r = v / 64'd506;
      default: r = v / 64'd600;
    endcase
    return r;
  endfunction

  // Rounded AMPLITUDE*sin(pi/2 * t/TABLE_LEN), Q61 Taylor series
  function automatic int quarter_sine(input int t);
    logic [63:0] x, x2, term, sum, v;
    if (t == 0) return 0;
    if (t == TABLE_LEN) return AMPLITUDE;
    if (3 * t == TABLE_LEN) return (AMPLITUDE + 1) / 2;
    x = (HALF_PI_Q61 / TABLE_LEN) * 64'(t)
        + ((HALF_PI_Q61 % TABLE_LEN) * 64'(t)) / TABLE_LEN;
    x2 = q61_mul(x, x);
    term = x;
    sum = x;
    for (int k = 1; k <= 12; k++) begin
      term = series_div(q61_mul(term, x2), k);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    v = (sum >> 20) * 64'(AMPLITUDE);
    return int'((v + (64'd1 << 40)) >> 41);
  endfunction

  function automatic int sine_entry(input int i);
    int  t;
    logic neg;
    t = 4 * i;
    neg = 1'b0;
    if (t > 2 * TABLE_LEN) begin
      t = t - 2 * TABLE_LEN;
      neg = 1'b1;
    end
    if (t > TABLE_LEN) t = 2 * TABLE_LEN - t;
    return neg ? -quarter_sine(t) : quarter_sine(t);
  endfunction

  logic [hsc_pkg::DATA_W-1:0] sine_const [TABLE_LEN];
  logic [AW-1:0]              idx;

  for (genvar i = 0; i < TABLE_LEN; i++) begin : g_entry
    localparam logic [hsc_pkg::DATA_W-1:0] ENTRY = hsc_pkg::DATA_W'(sine_entry(i));
    assign sine_const[i] = ENTRY;
  end

  // Sweep the table into the memories once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      if (idx == AW'(TABLE_LEN - 1)) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + AW'(1);
      end
    end
  end

  assign waddr = idx;
  assign wdata = sine_const[idx];

endmodule

// ----- sv/hsc_gain.sv -----
`include "hall_sine_commutation_core_defines.svh"

module hsc_gain #(
  parameter int WINDOW = hsc_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adc,
  input  logic [hsc_pkg::DATA_W-1:0] sample,
  input  logic [hsc_pkg::DATA_W-1:0] min_level,
  output logic [hsc_pkg::DATA_W-1:0] gain_level
);

  localparam int SUM_W     = hsc_pkg::SUM_W;
  localparam int CNT_W     = hsc_pkg::COUNT_W;
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W   = SUM_W + 1;
  localparam longint unsigned RECIP =
    ((longint'(1) << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);

  logic [SUM_W-1:0]           sample_sum, sum_inc, div_sum;
  logic [CNT_W-1:0]           sample_count, cnt_inc;
  logic                       div_go;
  logic [SUM_W+RECIP_W-1:0]   quot_wide;
  logic [hsc_pkg::DATA_W-1:0] avg;

  assign cnt_inc = sample_count + CNT_W'(1);
  assign sum_inc = sample_sum + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      div_go       <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (adc) begin
        if (cnt_inc == CNT_W'(WINDOW)) begin
          sample_sum   <= '0;
          sample_count <= '0;
          div_go       <= 1'b1;
        end else begin
          sample_sum   <= sum_inc;
          sample_count <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adc) begin
      div_sum <= sum_inc;
    end
  end

  // Exact floor division by the window through a reciprocal multiply
  assign quot_wide = (SUM_W+RECIP_W)'(div_sum) * (SUM_W+RECIP_W)'(RECIP);
  assign avg       = quot_wide[DIV_SHIFT +: hsc_pkg::DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_level <= '0;
    end else if (div_go) begin
      gain_level <= (avg < min_level) ? min_level : avg;
    end
  end

  `HSC_ASSERT(a_count_below_window, clk, rst, sample_count < CNT_W'(WINDOW),
              "sample count reached window without wrap")
  `HSC_ASSERT_NEXT(a_gain_floor, clk, rst, div_go, gain_level >= $past(min_level),
                   "gain level below floor after update")

endmodule

// ----- sv/hsc_drive_lane.sv -----
module hsc_drive_lane (
  input  logic                       clk,
  input  hsc_pkg::lane_ctl_t         ctl,
  input  logic [hsc_pkg::DATA_W-1:0] entry,
  input  logic [hsc_pkg::DATA_W-1:0] gain_level,
  input  logic [hsc_pkg::DATA_W-1:0] center_value,
  output logic [hsc_pkg::DATA_W-1:0] compare
);

  localparam int DW = hsc_pkg::DATA_W;
  localparam int SW = hsc_pkg::SCALE_W;

  logic [DW-1:0]               entry_neg;
  logic [hsc_pkg::MAG_W-1:0]   mag;
  logic [hsc_pkg::PROD_W-1:0]  prod;
  logic                        neg;
  logic [SW-1:0]               scaled_wide;
  logic [DW-1:0]               scaled;
  logic signed [DW+1:0]        level;
  logic [DW-1:0]               sat;

  assign entry_neg = -entry;
  assign mag       = entry[DW-1] ? entry_neg[hsc_pkg::MAG_W-1:0] : entry[hsc_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      prod <= hsc_pkg::PROD_W'(mag) * hsc_pkg::PROD_W'(gain_level);
      neg  <= entry[DW-1];
    end
  end

  // Truncate on the magnitude, then restore the sign
  assign scaled_wide = SW'(prod) * SW'(hsc_pkg::GAIN_MUL);
  assign scaled      = scaled_wide[hsc_pkg::GAIN_SHIFT +: DW];
  assign level       = neg ? $signed({2'b00, center_value}) - $signed({2'b00, scaled})
                           : $signed({2'b00, center_value}) + $signed({2'b00, scaled});

  always_comb begin
    priority if (level < 0) begin
      sat = '0;
    end else if (level > $signed((DW+2)'((1 << DW) - 1))) begin
      sat = '1;
    end else begin
      sat = level[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      compare <= sat;
    end
  end

endmodule
